>>> sv/skvt_pkg.sv
// Shared constants, types and codes of the sorted key/value table.
package skvt_pkg;

  localparam int CAPACITY   = 64;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int KEY_W      = 32;
  localparam int VAL_W      = 32;
  localparam int MODE_W     = 2;
  localparam int OUT_CNT_W  = 7;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NOP    = 2'd3;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_REPLACE,
    OP_INSERT,
    OP_DELETE
  } skvt_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } skvt_state_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic              write;
    skvt_op_t          op;
    logic              desc;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } skvt_cmd_t;

  // Handed from each cell to its right neighbor; the last cell's goes to the controller.
  typedef struct packed {
    logic              before_seen;
    logic              match_seen;
    logic [VAL_W-1:0]  found;
  } skvt_carry_t;

endpackage

>>> sv/skvt_ifs.sv
// Request and response channel interfaces of the sorted key/value table.
interface skvt_req_if import skvt_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic signed [KEY_W-1:0]  key;
  logic signed [VAL_W-1:0]  value;

  modport source (output valid, output mode, output key, output value, input ready);
  modport sink   (input valid, input mode, input key, input value, output ready);
endinterface

interface skvt_rsp_if import skvt_pkg::*;;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic signed [VAL_W-1:0]     found_value;
  logic                        full_reject;
  logic [OUT_CNT_W-1:0]        entry_count;
  logic                        is_empty;

  modport source (output valid, output hit, output found_value, output full_reject,
                  output entry_count, output is_empty, input ready);
  modport sink   (input valid, input hit, input found_value, input full_reject,
                  input entry_count, input is_empty, output ready);
endinterface

>>> sv/skvt_cell.sv
// One table slot: holds a key/value pair, compares it and shifts with its neighbors.
module skvt_cell import skvt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  skvt_cmd_t         cmd,
  input  logic              valid,
  input  skvt_carry_t       carry_in,
  input  logic [KEY_W-1:0]  left_key,
  input  logic [VAL_W-1:0]  left_value,
  input  logic [KEY_W-1:0]  right_key,
  input  logic [VAL_W-1:0]  right_value,
  output logic [KEY_W-1:0]  key_q,
  output logic [VAL_W-1:0]  value_q,
  output skvt_carry_t       carry_out
);

  logic [KEY_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] value_r, value_nxt;
  skvt_carry_t      carry_r, carry_nxt;
  logic             match;
  logic             slot_here;

  // An empty slot counts as "new key goes here", so the first empty slot
  // is the append position.
  assign match     = valid && (key_r == cmd.key);
  assign slot_here = !valid ||
                     (cmd.desc ? ($signed(cmd.key) > $signed(key_r))
                               : ($signed(cmd.key) < $signed(key_r)));

  always_comb begin
    carry_nxt.before_seen = carry_in.before_seen | slot_here;
    carry_nxt.match_seen  = carry_in.match_seen | match;
    carry_nxt.found       = (match && !carry_in.match_seen) ? value_r : carry_in.found;
  end

  always_comb begin
    key_nxt   = key_r;
    value_nxt = value_r;
    if (cmd.write) begin
      case (cmd.op)
        OP_REPLACE: begin
          if (match) value_nxt = cmd.value;
        end
        OP_INSERT: begin
          // shift up behind the slot, drop the new pair into the slot
          if (carry_in.before_seen) begin
            key_nxt   = left_key;
            value_nxt = left_value;
          end else if (slot_here) begin
            key_nxt   = cmd.key;
            value_nxt = cmd.value;
          end
        end
        OP_DELETE: begin
          // close the gap from the right
          if (carry_in.match_seen || match) begin
            key_nxt   = right_key;
            value_nxt = right_value;
          end
        end
        default: begin
          key_nxt   = key_r;
          value_nxt = value_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
    if (!rst_n) begin
      carry_r <= '0;
    end else begin
      carry_r <= carry_nxt;
    end
  end

  assign key_q     = key_r;
  assign value_q   = value_r;
  assign carry_out = carry_r;

endmodule

>>> sv/skvt_ctrl.sv
// Request sequencer: holds the request, times the scan, commits and builds the result.
module skvt_ctrl import skvt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  sort_order,
  input  logic                  in_valid,
  input  logic [MODE_W-1:0]     in_mode,
  input  logic [KEY_W-1:0]      in_key,
  input  logic [VAL_W-1:0]      in_value,
  output logic                  in_ready,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic                  out_hit,
  output logic [VAL_W-1:0]      out_found_value,
  output logic                  out_full_reject,
  output logic [OUT_CNT_W-1:0]  out_entry_count,
  output logic                  out_is_empty,
  input  skvt_carry_t           tail_carry,
  output skvt_cmd_t             cmd,
  output logic [CNT_W-1:0]      count
);

  skvt_state_t          state_r, state_nxt;
  logic [IDX_W-1:0]     step_r, step_nxt;
  logic [MODE_W-1:0]    mode_r, mode_nxt;
  logic [KEY_W-1:0]     key_r, key_nxt;
  logic [VAL_W-1:0]     value_r, value_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 hit_r, hit_nxt;
  logic [VAL_W-1:0]     found_r, found_nxt;
  logic                 reject_r, reject_nxt;
  logic [OUT_CNT_W-1:0] ecount_r, ecount_nxt;
  logic                 empty_r, empty_nxt;
  logic                 hit;
  logic                 full;
  logic                 commit;
  skvt_op_t             op;

  assign hit  = (mode_r != MODE_NOP) && tail_carry.match_seen;
  assign full = (count_r == CNT_W'(CAPACITY));

  always_comb begin
    case (mode_r)
      MODE_INSERT: op = hit ? OP_REPLACE : (full ? OP_NONE : OP_INSERT);
      MODE_DELETE: op = hit ? OP_DELETE : OP_NONE;
      default:     op = OP_NONE;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    mode_nxt      = mode_r;
    key_nxt       = key_r;
    value_nxt     = value_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ready;
    hit_nxt       = hit_r;
    found_nxt     = found_r;
    reject_nxt    = reject_r;
    ecount_nxt    = ecount_r;
    empty_nxt     = empty_r;
    commit        = 1'b0;
    in_ready      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          mode_nxt  = in_mode;
          key_nxt   = in_key;
          value_nxt = in_value;
          step_nxt  = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // let the carry ripple through every cell
        step_nxt = step_r + 1'b1;
        if (step_r == IDX_W'(CAPACITY - 1)) state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (!out_valid_r || out_ready) begin
          commit = 1'b1;
          case (op)
            OP_INSERT: count_nxt = count_r + 1'b1;
            OP_DELETE: count_nxt = count_r - 1'b1;
            default:   count_nxt = count_r;
          endcase
          out_valid_nxt = 1'b1;
          hit_nxt       = hit;
          found_nxt     = hit ? tail_carry.found : '0;
          reject_nxt    = (mode_r == MODE_INSERT) && !hit && full;
          ecount_nxt    = OUT_CNT_W'(count_nxt);
          empty_nxt     = (count_nxt == '0);
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    key_r    <= key_nxt;
    value_r  <= value_nxt;
    step_r   <= step_nxt;
    hit_r    <= hit_nxt;
    found_r  <= found_nxt;
    reject_r <= reject_nxt;
    ecount_r <= ecount_nxt;
    empty_r  <= empty_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign cmd.write = commit;
  assign cmd.op    = op;
  assign cmd.desc  = sort_order;
  assign cmd.key   = key_r;
  assign cmd.value = value_r;
  assign count     = count_r;

  assign out_valid       = out_valid_r;
  assign out_hit         = hit_r;
  assign out_found_value = found_r;
  assign out_full_reject = reject_r;
  assign out_entry_count = ecount_r;
  assign out_is_empty    = empty_r;

endmodule

>>> sv/sorted_key_value_table_core.sv
// Sorted key/value table of CAPACITY pairs (64) built as a chain of slot cells. A request
// (insert or replace, lookup, delete) is latched at its transfer. The controller then scans
// while the compare carry (match seen, slot seen, found value) ripples one cell per clock
// down the chain, and then commits: every cell shifts, takes the new pair or keeps its own,
// and the result is registered. The next request is taken in the cycle after the commit, so
// no new request is taken while one is in flight, though its result may still wait in the
// output register; a result still waiting when the next commit comes holds that commit.
// sort_order (0 ascending, 1 descending) is applied to new inserts only; the table is not
// re-sorted when it changes. Write it only while the block is idle.
module sorted_key_value_table_core import skvt_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  skvt_req_if.sink     in_ch,
  skvt_rsp_if.source   out_ch,
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data
);

  logic              sort_order_r;
  skvt_cmd_t         cmd;
  logic [CNT_W-1:0]  count;
  skvt_carry_t       carry   [CAPACITY];
  logic [KEY_W-1:0]  key_q   [CAPACITY];
  logic [VAL_W-1:0]  value_q [CAPACITY];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sort_order_r <= 1'b0;
    end else if (cfg_wr_en) begin
      sort_order_r <= cfg_wr_data;
    end
  end

  skvt_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .sort_order      (sort_order_r),
    .in_valid        (in_ch.valid),
    .in_mode         (in_ch.mode),
    .in_key          (in_ch.key),
    .in_value        (in_ch.value),
    .in_ready        (in_ch.ready),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_hit         (out_ch.hit),
    .out_found_value (out_ch.found_value),
    .out_full_reject (out_ch.full_reject),
    .out_entry_count (out_ch.entry_count),
    .out_is_empty    (out_ch.is_empty),
    .tail_carry      (carry[CAPACITY-1]),
    .cmd             (cmd),
    .count           (count)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    skvt_carry_t       cin;
    logic [KEY_W-1:0]  lkey, rkey;
    logic [VAL_W-1:0]  lval, rval;
    logic              slot_valid;

    assign slot_valid = (CNT_W'(i) < count);

    if (i == 0) begin : g_head
      assign cin  = '0;
      assign lkey = key_q[i];
      assign lval = value_q[i];
    end else begin : g_body
      assign cin  = carry[i-1];
      assign lkey = key_q[i-1];
      assign lval = value_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign rkey = key_q[i];
      assign rval = value_q[i];
    end else begin : g_inner
      assign rkey = key_q[i+1];
      assign rval = value_q[i+1];
    end

    skvt_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .valid       (slot_valid),
      .carry_in    (cin),
      .left_key    (lkey),
      .left_value  (lval),
      .right_key   (rkey),
      .right_value (rval),
      .key_q       (key_q[i]),
      .value_q     (value_q[i]),
      .carry_out   (carry[i])
    );
  end

endmodule

>>> sv/skvt_checker.sv
// Port-level checks of the sorted key/value table, bound to the top level.
module skvt_checker import skvt_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  out_hit,
  input logic [VAL_W-1:0]      out_found_value,
  input logic                  out_full_reject,
  input logic [OUT_CNT_W-1:0]  out_entry_count,
  input logic                  out_is_empty
);

  // a request makes the table busy as soon as it is taken
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a transfer");

  a_miss_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_found_value == '0)
    else $error("found_value nonzero without a hit");

  a_hit_not_rejected: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_full_reject))
    else $error("hit and full_reject together");

  a_empty_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_is_empty == (out_entry_count == '0))
    else $error("is_empty disagrees with entry_count");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found_value) && $stable(out_hit))
    else $error("stalled result changed");

endmodule

bind sorted_key_value_table_core skvt_checker u_skvt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_hit         (out_ch.hit),
  .out_found_value (out_ch.found_value),
  .out_full_reject (out_ch.full_reject),
  .out_entry_count (out_ch.entry_count),
  .out_is_empty    (out_ch.is_empty)
);
